>>> src/rtws_pkg.sv
`default_nettype none
package rtws_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = IDX_W + 1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_PRUNE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [23:0] LOSS_SCALE = 24'd10000;
  localparam logic [31:0] WL_RESET   = 32'd10000000;

  localparam int unsigned DIV_W  = 56;
  localparam int unsigned SQ_W   = 56;
  localparam int unsigned SQ_STEPS = SQ_W / 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [39:0] sent_time;
    logic        probe_ok;
    logic [31:0] responder_id;
    logic [23:0] rtt_in;
    logic [39:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  sample_count;
    logic        loss_valid;
    logic [13:0] loss_hundredths;
    logic [23:0] last_rtt;
    logic [23:0] best_rtt;
    logic [23:0] worst_rtt;
    logic [23:0] mean_rtt;
    logic        jitter_valid;
    logic [23:0] jitter_rtt;
    logic        deviation_valid;
    logic [23:0] deviation_rtt;
  } out_item_t;

  typedef struct packed {
    logic [39:0] sent_time;
    logic        ok;
    logic [31:0] responder;
    logic [23:0] rtt;
  } entry_t;

endpackage
`default_nettype wire

>>> src/rtt_window_statistics_top.sv
// An add shifts later entries up one place each until it settles on a compare; when the window is
// full it first drops the oldest entry, or discards the new one if the oldest is later. A prune
// drops entries from the head until it stops on a kept entry. A query walks the window, then uses
// up to four divisions and a 28-step root; out_valid rises in the same cycle that busy falls.
// Throughput: one item at a time, set by the single memory read port, the shared divider and the
// shared 24x24 multiplier. Reset clears the fill level and loads window_length with 10000000;
// window memory is not cleared. Results show for one cycle on out_valid; receiver cannot stall.
`default_nettype none
module rtt_window_statistics_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  rtws_pkg::in_item_t  in_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [31:0]         cfg_data,
  output logic                out_valid,
  output rtws_pkg::out_item_t out_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] A_START   = 5'd1;
  localparam logic [4:0] A_FULLCMP = 5'd2;
  localparam logic [4:0] A_RD      = 5'd3;
  localparam logic [4:0] A_CMP     = 5'd4;
  localparam logic [4:0] P_START   = 5'd5;
  localparam logic [4:0] P_RD      = 5'd6;
  localparam logic [4:0] P_CMP     = 5'd7;
  localparam logic [4:0] Q_INIT    = 5'd8;
  localparam logic [4:0] Q_RD      = 5'd9;
  localparam logic [4:0] Q_ACC     = 5'd10;
  localparam logic [4:0] Q_LMUL    = 5'd11;
  localparam logic [4:0] Q_LDIV    = 5'd12;
  localparam logic [4:0] Q_LDONE   = 5'd13;
  localparam logic [4:0] Q_MDONE   = 5'd14;
  localparam logic [4:0] Q_JDONE   = 5'd15;
  localparam logic [4:0] Q_VRD     = 5'd16;
  localparam logic [4:0] Q_VSUB    = 5'd17;
  localparam logic [4:0] Q_VACC    = 5'd18;
  localparam logic [4:0] Q_SDONE   = 5'd19;
  localparam logic [4:0] Q_EMUL    = 5'd20;
  localparam logic [4:0] Q_RMUL    = 5'd21;
  localparam logic [4:0] Q_SQRT    = 5'd22;
  localparam logic [4:0] Q_OUT     = 5'd23;
  localparam logic [4:0] S_DIV     = 5'd24;

  localparam int unsigned IW = rtws_pkg::IDX_W;
  localparam int unsigned CW = rtws_pkg::CNT_W;
  localparam int unsigned DW = rtws_pkg::DIV_W;
  localparam int unsigned QW = rtws_pkg::SQ_W;

  rtws_pkg::entry_t mem [rtws_pkg::DEPTH];
  rtws_pkg::entry_t rd_r;
  logic             mem_we;
  logic [IW-1:0]    mem_wa, mem_ra;
  rtws_pkg::entry_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  logic [23:0] mul_a, mul_b;
  logic [47:0] prod_r;
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  logic [4:0]  state_r, state_nxt, div_ret_r, div_ret_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt, pos_r, pos_nxt, idx_r, idx_nxt;
  logic [31:0] wl_r, wl_nxt;
  rtws_pkg::in_item_t item_r, item_nxt;
  logic [39:0] cut_r, cut_nxt;
  logic [CW-1:0] lost_r, lost_nxt, n_r, n_nxt, pairs_r, pairs_nxt;
  logic [32:0] sum_r, sum_nxt, dsum_r, dsum_nxt;
  logic [23:0] best_r, best_nxt, worst_r, worst_nxt, last_r, last_nxt;
  logic [23:0] prev_v_r, prev_v_nxt, mean_r, mean_nxt, jit_r, jit_nxt;
  logic        prev_m_r, prev_m_nxt;
  logic [CW-2:0] mrem_r, mrem_nxt;
  logic [13:0] loss_r, loss_nxt;
  logic [DW-1:0] s2_r, s2_nxt;
  logic [15:0] en_r, en_nxt;
  logic [QW-1:0] sx_r, sx_nxt, sr_r, sr_nxt, sb_r, sb_nxt;
  logic [4:0]  sq_cnt_r, sq_cnt_nxt;
  logic [DW-1:0] dq_r, dq_nxt;
  logic [CW-1:0] drem_r, drem_nxt, dden_r, dden_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  rtws_pkg::out_item_t out_r, out_nxt;

  logic          match;
  logic [23:0]   vdiff, mdiff;
  logic [CW:0]   drs;
  logic          dge;
  logic [QW-1:0] sq_try;
  logic          load_div;
  logic [DW-1:0] ld_num;
  logic [CW-1:0] ld_den;
  logic [4:0]    ld_ret;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    match = rd_r.ok && (rd_r.responder == item_r.responder_id) &&
            (item_r.responder_id != 32'd0);
    vdiff = (rd_r.rtt > prev_v_r) ? rd_r.rtt - prev_v_r : prev_v_r - rd_r.rtt;
    mdiff = (rd_r.rtt > mean_r) ? rd_r.rtt - mean_r : mean_r - rd_r.rtt;
    drs   = {drem_r, dq_r[DW-1]};
    dge   = (drs >= {1'b0, dden_r});
    sq_try = sr_r + sb_r;

    state_nxt = state_r;   div_ret_nxt = div_ret_r;
    head_nxt = head_r;     fill_nxt = fill_r;   pos_nxt = pos_r;   idx_nxt = idx_r;
    wl_nxt = wl_r;         item_nxt = item_r;   cut_nxt = cut_r;
    lost_nxt = lost_r;     n_nxt = n_r;         pairs_nxt = pairs_r;
    sum_nxt = sum_r;       dsum_nxt = dsum_r;
    best_nxt = best_r;     worst_nxt = worst_r; last_nxt = last_r;
    prev_v_nxt = prev_v_r; prev_m_nxt = prev_m_r;
    mean_nxt = mean_r;     jit_nxt = jit_r;     mrem_nxt = mrem_r;
    loss_nxt = loss_r;     s2_nxt = s2_r;       en_nxt = en_r;
    sx_nxt = sx_r;         sr_nxt = sr_r;       sb_nxt = sb_r;     sq_cnt_nxt = sq_cnt_r;
    dq_nxt = dq_r;         drem_nxt = drem_r;   dden_nxt = dden_r; dcnt_nxt = dcnt_r;
    out_valid_nxt = 1'b0;  out_nxt = out_r;

    mem_we = 1'b0;
    mem_wa = head_r + pos_r[IW-1:0];
    mem_ra = head_r;
    mem_wd = rd_r;
    mul_a  = '0;
    mul_b  = '0;
    load_div = 1'b0;
    ld_num = '0;
    ld_den = '0;
    ld_ret = S_IDLE;

    if (cfg_valid) begin
      wl_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          case (in_data.op)
            rtws_pkg::OP_ADD:   state_nxt = A_START;
            rtws_pkg::OP_PRUNE: state_nxt = P_START;
            rtws_pkg::OP_QUERY: state_nxt = Q_INIT;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      A_START: begin
        pos_nxt = fill_r;
        state_nxt = (fill_r == CW'(rtws_pkg::DEPTH)) ? A_FULLCMP : A_RD;
      end
      A_FULLCMP: begin
        // oldest sample later than the new one: insert and drop cancel out
        if (rd_r.sent_time > item_r.sent_time) begin
          state_nxt = S_IDLE;
        end else begin
          head_nxt  = head_r + 1'b1;
          fill_nxt  = fill_r - 1'b1;
          pos_nxt   = fill_r - 1'b1;
          state_nxt = A_RD;
        end
      end
      A_RD: begin
        mem_ra = head_r + pos_r[IW-1:0] - 1'b1;
        if (pos_r == '0) begin
          mem_we = 1'b1;
          mem_wd = '{item_r.sent_time, item_r.probe_ok, item_r.responder_id, item_r.rtt_in};
          fill_nxt = fill_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = A_CMP;
        end
      end
      A_CMP: begin
        mem_we = 1'b1;
        if (rd_r.sent_time > item_r.sent_time) begin
          mem_wd  = rd_r;
          pos_nxt = pos_r - 1'b1;
          state_nxt = A_RD;
        end else begin
          mem_wd = '{item_r.sent_time, item_r.probe_ok, item_r.responder_id, item_r.rtt_in};
          fill_nxt = fill_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      P_START: begin
        cut_nxt = item_r.now_time - {8'd0, wl_r};
        state_nxt = (item_r.now_time < {8'd0, wl_r}) ? S_IDLE : P_RD;
      end
      P_RD: begin
        state_nxt = (fill_r == '0) ? S_IDLE : P_CMP;
      end
      P_CMP: begin
        if (rd_r.sent_time <= cut_r) begin
          head_nxt  = head_r + 1'b1;
          fill_nxt  = fill_r - 1'b1;
          state_nxt = P_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      Q_INIT: begin
        idx_nxt = '0; lost_nxt = '0; n_nxt = '0; pairs_nxt = '0;
        sum_nxt = '0; dsum_nxt = '0; prev_m_nxt = 1'b0;
        best_nxt = '0; worst_nxt = '0; last_nxt = '0;
        state_nxt = Q_RD;
      end
      Q_RD: begin
        mem_ra = head_r + idx_r[IW-1:0];
        state_nxt = (idx_r == fill_r) ? Q_LMUL : Q_ACC;
      end
      Q_ACC: begin
        if (!rd_r.ok) begin
          lost_nxt = lost_r + 1'b1;
        end
        if (match) begin
          if (n_r == '0 || rd_r.rtt < best_r)  best_nxt  = rd_r.rtt;
          if (n_r == '0 || rd_r.rtt > worst_r) worst_nxt = rd_r.rtt;
          last_nxt = rd_r.rtt;
          sum_nxt  = sum_r + 33'(rd_r.rtt);
          n_nxt    = n_r + 1'b1;
          if (prev_m_r) begin
            dsum_nxt  = dsum_r + 33'(vdiff);
            pairs_nxt = pairs_r + 1'b1;
          end
        end
        prev_m_nxt = match;
        prev_v_nxt = rd_r.rtt;
        idx_nxt = idx_r + 1'b1;
        state_nxt = Q_RD;
      end
      Q_LMUL: begin
        mul_a = 24'(lost_r);
        mul_b = rtws_pkg::LOSS_SCALE;
        state_nxt = Q_LDIV;
      end
      Q_LDIV: begin
        load_div = 1'b1;
        ld_num = DW'(prod_r[21:0]);
        ld_den = fill_r;
        ld_ret = Q_LDONE;
      end
      Q_LDONE: begin
        loss_nxt = (fill_r == '0) ? 14'd0 : dq_r[13:0];
        if (n_r == '0) begin
          state_nxt = Q_OUT;
        end else begin
          load_div = 1'b1;
          ld_num = DW'(sum_r);
          ld_den = n_r;
          ld_ret = Q_MDONE;
        end
      end
      Q_MDONE: begin
        mean_nxt = dq_r[23:0];
        mrem_nxt = drem_r[CW-2:0];
        load_div = 1'b1;
        ld_num = DW'(dsum_r);
        ld_den = pairs_r;
        ld_ret = Q_JDONE;
      end
      Q_JDONE: begin
        jit_nxt = dq_r[23:0];
        idx_nxt = '0;
        s2_nxt  = '0;
        state_nxt = (n_r < CW'(2)) ? Q_OUT : Q_VRD;
      end
      Q_VRD: begin
        mem_ra = head_r + idx_r[IW-1:0];
        if (idx_r == fill_r) begin
          load_div = 1'b1;
          ld_num = s2_r;
          ld_den = n_r - 1'b1;
          ld_ret = Q_SDONE;
        end else begin
          state_nxt = Q_VSUB;
        end
      end
      Q_VSUB: begin
        mul_a = match ? mdiff : 24'd0;
        mul_b = match ? mdiff : 24'd0;
        state_nxt = Q_VACC;
      end
      Q_VACC: begin
        s2_nxt  = s2_r + DW'(prod_r);
        idx_nxt = idx_r + 1'b1;
        state_nxt = Q_VRD;
      end
      Q_SDONE: begin
        sx_nxt = dq_r;
        mul_a = 24'(drem_r);
        mul_b = 24'(n_r);
        state_nxt = Q_EMUL;
      end
      Q_EMUL: begin
        en_nxt = prod_r[15:0];
        mul_a = 24'(mrem_r);
        mul_b = 24'(mrem_r);
        state_nxt = Q_RMUL;
      end
      Q_RMUL: begin
        // correction for the truncated mean lowers the quotient by at most one
        if (prod_r[15:0] > en_r && sx_r != '0) begin
          sx_nxt = sx_r - 1'b1;
        end
        sr_nxt = '0;
        sb_nxt = QW'(1) << (QW - 2);
        sq_cnt_nxt = 5'(rtws_pkg::SQ_STEPS - 1);
        state_nxt = Q_SQRT;
      end
      Q_SQRT: begin
        if (sx_r >= sq_try) begin
          sx_nxt = sx_r - sq_try;
          sr_nxt = (sr_r >> 1) + sb_r;
        end else begin
          sr_nxt = sr_r >> 1;
        end
        sb_nxt = sb_r >> 2;
        sq_cnt_nxt = sq_cnt_r - 1'b1;
        if (sq_cnt_r == '0) begin
          state_nxt = Q_OUT;
        end
      end
      Q_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt.sample_count    = n_r;
        out_nxt.loss_valid      = (fill_r != '0);
        out_nxt.loss_hundredths = loss_r;
        out_nxt.last_rtt        = last_r;
        out_nxt.best_rtt        = best_r;
        out_nxt.worst_rtt       = worst_r;
        out_nxt.mean_rtt        = (n_r != '0) ? mean_r : 24'd0;
        out_nxt.jitter_valid    = (pairs_r >= CW'(2));
        out_nxt.jitter_rtt      = (pairs_r >= CW'(2)) ? jit_r : 24'd0;
        out_nxt.deviation_valid = (n_r >= CW'(2));
        out_nxt.deviation_rtt   = (n_r >= CW'(2)) ? sr_r[23:0] : 24'd0;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        drem_nxt = dge ? CW'(drs - {1'b0, dden_r}) : drs[CW-1:0];
        dq_nxt   = {dq_r[DW-2:0], dge};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          state_nxt = div_ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_div) begin
      dq_nxt      = ld_num;
      drem_nxt    = '0;
      dden_nxt    = ld_den;
      dcnt_nxt    = 6'(DW - 1);
      div_ret_nxt = ld_ret;
      state_nxt   = S_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      head_r      <= '0;
      wl_r        <= rtws_pkg::WL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      wl_r        <= wl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_ret_r <= div_ret_nxt;  pos_r <= pos_nxt;     idx_r <= idx_nxt;
    item_r <= item_nxt;        cut_r <= cut_nxt;
    lost_r <= lost_nxt;        n_r <= n_nxt;         pairs_r <= pairs_nxt;
    sum_r <= sum_nxt;          dsum_r <= dsum_nxt;
    best_r <= best_nxt;        worst_r <= worst_nxt; last_r <= last_nxt;
    prev_v_r <= prev_v_nxt;    prev_m_r <= prev_m_nxt;
    mean_r <= mean_nxt;        jit_r <= jit_nxt;     mrem_r <= mrem_nxt;
    loss_r <= loss_nxt;        s2_r <= s2_nxt;       en_r <= en_nxt;
    sx_r <= sx_nxt;            sr_r <= sr_nxt;       sb_r <= sb_nxt;     sq_cnt_r <= sq_cnt_nxt;
    dq_r <= dq_nxt;            drem_r <= drem_nxt;   dden_r <= dden_nxt; dcnt_r <= dcnt_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int unsigned RANDOM_ITEMS = 580;
  localparam int unsigned TAIL_CYCLES = 2000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  rtws_pkg::in_item_t  in_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_data;
  logic      out_valid;
  rtws_pkg::out_item_t out_data;

  rtt_window_statistics_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_data(out_data)
  );

  // shadow of the window, kept in send-time order
  logic [39:0] win_time [rtws_pkg::DEPTH+1];
  logic        win_ok   [rtws_pkg::DEPTH+1];
  logic [31:0] win_who  [rtws_pkg::DEPTH+1];
  logic [23:0] win_rtt  [rtws_pkg::DEPTH+1];
  int unsigned win_fill;
  logic [31:0] win_len;

  rtws_pkg::out_item_t stats_due [$];
  int unsigned mismatches;
  bit          failed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void win_drop(int unsigned k);
    int unsigned i;
    if (k > win_fill) k = win_fill;
    for (i = 0; i + k < win_fill; i++) begin
      win_time[i] = win_time[i+k];
      win_ok[i]   = win_ok[i+k];
      win_who[i]  = win_who[i+k];
      win_rtt[i]  = win_rtt[i+k];
    end
    win_fill = win_fill - k;
  endfunction

  function automatic void win_insert(rtws_pkg::in_item_t it);
    int unsigned pos, i;
    pos = win_fill;
    while (pos > 0 && win_time[pos-1] > it.sent_time) pos--;
    for (i = win_fill; i > pos; i--) begin
      win_time[i] = win_time[i-1];
      win_ok[i]   = win_ok[i-1];
      win_who[i]  = win_who[i-1];
      win_rtt[i]  = win_rtt[i-1];
    end
    win_time[pos] = it.sent_time;
    win_ok[pos]   = it.probe_ok;
    win_who[pos]  = it.responder_id;
    win_rtt[pos]  = it.rtt_in;
    win_fill++;
    if (win_fill > rtws_pkg::DEPTH) win_drop(win_fill - rtws_pkg::DEPTH);
  endfunction

  function automatic void win_prune(logic [39:0] now);
    logic [39:0] cut;
    int unsigned k;
    k = 0;
    if (now < {8'd0, win_len}) return;
    cut = now - {8'd0, win_len};
    while (k < win_fill && win_time[k] <= cut) k++;
    win_drop(k);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic rtws_pkg::out_item_t responder_stats(logic [31:0] who);
    rtws_pkg::out_item_t o;
    int unsigned i, lost, n, pairs;
    longint unsigned sum, dsum, v, p, best, worst, last, m, r, s2, q1, e1, d;
    longint rem, den, adj;
    o = '0;
    lost = 0; n = 0; pairs = 0;
    sum = 0; dsum = 0; best = 0; worst = 0; last = 0; s2 = 0;
    for (i = 0; i < win_fill; i++) if (!win_ok[i]) lost++;
    if (win_fill > 0) begin
      o.loss_valid = 1'b1;
      o.loss_hundredths = 14'(longint'(lost) * 10000 / win_fill);
    end
    if (who == 0) return o;
    for (i = 0; i < win_fill; i++) begin
      if (!win_ok[i] || win_who[i] != who) continue;
      v = win_rtt[i];
      if (n == 0 || v < best) best = v;
      if (n == 0 || v > worst) worst = v;
      last = v;
      sum += v;
      n++;
      if (i > 0 && win_ok[i-1] && win_who[i-1] == who) begin
        p = win_rtt[i-1];
        dsum += (v > p) ? v - p : p - v;
        pairs++;
      end
    end
    o.sample_count = 9'(n);
    if (n == 0) return o;
    o.last_rtt  = 24'(last);
    o.best_rtt  = 24'(best);
    o.worst_rtt = 24'(worst);
    o.mean_rtt  = 24'(sum / n);
    if (pairs >= 2) begin
      o.jitter_valid = 1'b1;
      o.jitter_rtt   = 24'(dsum / pairs);
    end
    if (n >= 2) begin
      // variance about the floor mean, then corrected for the fractional part
      m = sum / n;
      r = sum - m * n;
      for (i = 0; i < win_fill; i++) begin
        if (!win_ok[i] || win_who[i] != who) continue;
        v = win_rtt[i];
        d = (v > m) ? v - m : m - v;
        s2 += d * d;
      end
      q1 = s2 / (n - 1);
      e1 = s2 % (n - 1);
      rem = longint'(e1 * n) - longint'(r * r);
      den = longint'(n) * longint'(n - 1);
      if (rem >= 0) adj = rem / den;
      else adj = -((-rem + den - 1) / den);
      if (adj < 0 && q1 < unsigned'(-adj)) q1 = 0;
      else q1 = unsigned'(longint'(q1) + adj);
      o.deviation_valid = 1'b1;
      o.deviation_rtt   = 24'(int_sqrt(q1));
    end
    return o;
  endfunction

  // results are taken at the edge that ends their strobe cycle
  always @(posedge clk) begin
    rtws_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (stats_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = stats_due.pop_front();
        if (out_data !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  // drop start only when the pause lasts at least one edge
  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // hand one item over and update the shadow window once busy falls
  task automatic send_item(rtws_pkg::in_item_t it, bit gaps);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (it.op)
      rtws_pkg::OP_ADD:   win_insert(it);
      rtws_pkg::OP_PRUNE: win_prune(it.now_time);
      rtws_pkg::OP_QUERY: stats_due.insert(stats_due.size(), responder_stats(it.responder_id));
      default: ;
    endcase
    if (gaps && $urandom_range(0, 3) == 0) begin
      idle_gap();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (stats_due.size() != 0 || busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_length(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_len = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic rtws_pkg::in_item_t make_item(logic [1:0] op, logic [39:0] t, logic ok,
                                                   logic [31:0] who, logic [23:0] rtt,
                                                   logic [39:0] now);
    rtws_pkg::in_item_t it;
    it.op = op; it.sent_time = t; it.probe_ok = ok;
    it.responder_id = who; it.rtt_in = rtt; it.now_time = now;
    return it;
  endfunction

  typedef struct {
    rtws_pkg::in_item_t  item;
    bit                  fixed;
    rtws_pkg::out_item_t stats;
  } step_row_t;

  step_row_t   steps [$];
  logic [39:0] clock_us;
  logic [31:0] peers [4];

  function automatic void add_step(step_row_t r);
    steps.insert(steps.size(), r);
  endfunction

  initial begin
    step_row_t row;
    rtws_pkg::in_item_t  it;
    int unsigned k, phase, sel;
    rtws_pkg::out_item_t z;
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    win_fill = 0; win_len = rtws_pkg::WL_RESET; mismatches = 0; failed = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    z = '0;
    row.fixed = 1'b1; row.stats = z;
    row.item = make_item(rtws_pkg::OP_QUERY, 0, 0, 32'd5, 0, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_QUERY, 0, 0, 32'd0, 0, 0);
    add_step(row);
    row.fixed = 1'b0;
    row.item = make_item(rtws_pkg::OP_ADD, 40'd100, 1, 32'hFFFF_FFFF, 24'hFF_FFFF, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_ADD, 40'd100, 1, 32'hFFFF_FFFF, 24'd0, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_ADD, 40'd50, 1, 32'hFFFF_FFFF, 24'd7, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_ADD, 40'hFF_FFFF_FFFF, 0, 32'd0, 24'hAAAAAA, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_ADD, 40'd120, 1, 32'd0, 24'h555555, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_ADD, 40'd130, 1, 32'hFFFF_FFFF, 24'd9, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_QUERY, 0, 0, 32'hFFFF_FFFF, 0, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_QUERY, 0, 0, 32'd0, 0, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_QUERY, 0, 0, 32'd77, 0, 0);
    add_step(row);
    row.item = make_item(2'd3, 40'hFF_FFFF_FFFF, 1, 32'hFFFF_FFFF, 24'hFF_FFFF,
                         40'hFF_FFFF_FFFF);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_PRUNE, 0, 0, 0, 0, 40'd5);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_PRUNE, 0, 0, 0, 0, 40'd10000110);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_QUERY, 0, 0, 32'hFFFF_FFFF, 0, 0);
    add_step(row);
    row.item = make_item(rtws_pkg::OP_PRUNE, 0, 0, 0, 0, 40'hFF_FFFF_FFFF);
    add_step(row);
    // only the late timeout is left: full loss, no samples for the responder
    row.fixed = 1'b1;
    row.stats = z;
    row.stats.loss_valid = 1'b1;
    row.stats.loss_hundredths = 14'd10000;
    row.item = make_item(rtws_pkg::OP_QUERY, 0, 0, 32'hFFFF_FFFF, 0, 0);
    add_step(row);
    foreach (steps[i]) begin
      send_item(steps[i].item, 1'b0);
      if (steps[i].fixed) stats_due[stats_due.size()-1] = steps[i].stats;
    end
    drain();

    // random phases across window lengths, extremes included
    clock_us = 40'd1000;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_window_length(32'd0);
        1: write_window_length(32'hFFFF_FFFF);
        2: write_window_length(32'd1);
        3: write_window_length($urandom_range(200, 3000));
        4: write_window_length($urandom());
        default: write_window_length($urandom_range(50, 800));
      endcase
      for (k = 0; k < 4; k++) peers[k] = (k == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 1000);
      for (k = 0; k < RANDOM_ITEMS / 6; k++) begin
        sel = $urandom_range(0, 99);
        it = '0;
        it.sent_time = $urandom();
        it.now_time  = 40'({$urandom(), $urandom()});
        it.rtt_in    = 24'($urandom());
        it.responder_id = $urandom();
        it.probe_ok  = 1'($urandom_range(0, 1));
        if (sel < 60) begin
          it.op = rtws_pkg::OP_ADD;
          clock_us = clock_us + $urandom_range(0, 40);
          it.sent_time = ($urandom_range(0, 7) == 0)
                         ? clock_us - $urandom_range(0, 300) : clock_us;
          if ($urandom_range(0, 15) == 0) it.sent_time = 40'({$urandom(), $urandom()});
          it.probe_ok = ($urandom_range(0, 4) != 0);
          it.responder_id = ($urandom_range(0, 9) == 0) ? 32'd0 : peers[$urandom_range(0, 3)];
          it.rtt_in = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                                   : 24'($urandom_range(0, 5000));
        end else if (sel < 70) begin
          it.op = rtws_pkg::OP_PRUNE;
          if ($urandom_range(0, 3) != 0) it.now_time = clock_us + $urandom_range(0, 100);
        end else if (sel < 97) begin
          it.op = rtws_pkg::OP_QUERY;
          if ($urandom_range(0, 5) != 0) it.responder_id = peers[$urandom_range(0, 3)];
        end else begin
          it.op = 2'd3;
        end
        send_item(it, 1'b1);
        if (phase == 2 && k == 40) drain();
      end
      drain();
    end

    if (!failed) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
